[src/wrv_pkg.sv]
// Shared types and constants for the Welford row mean and variance block.
// Used by the sequencer, the shared arithmetic unit and the top level.
// No dependencies.
package wrv_pkg;

  // Field and state widths
  localparam int SAMPLE_W = 16;   // Q8.8 sample
  localparam int CFG_W    = 13;   // row length register
  localparam int CNT_W    = 13;   // sample count and divisor
  localparam int MEAN_W   = 32;   // Q16.16 running mean
  localparam int SUM_W    = 64;   // Q32.32 deviation sum
  localparam int DELTA_W  = 33;   // difference of sample and mean
  localparam int QUO_W    = 48;   // divider dividend and quotient
  localparam int VAR_W    = 32;   // Q16.16 variance
  localparam int FRAC_SH  = 8;    // Q8.8 to Q16.16 shift
  localparam int VAR_SH   = 16;   // Q32.32 to Q16.16 shift
  localparam int STEP_W   = 6;

  // Iteration counts of the shared unit
  localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(DELTA_W);
  localparam logic [STEP_W-1:0] MUL_STEPS  = STEP_W'(DELTA_W);
  localparam logic [STEP_W-1:0] VAR_STEPS  = STEP_W'(QUO_W);

  localparam logic [CNT_W-1:0] MAX_ROW_LENGTH = CNT_W'(4096);
  localparam logic [CFG_W-1:0] ROW_LEN_RESET  = CFG_W'(128);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_MEAN_UPD,
    ST_MUL_LOAD,
    ST_MUL,
    ST_ACC,
    ST_DIV_VAR,
    ST_RESULT
  } wrv_state_e;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } wrv_op_e;

  // Commands from the sequencer to the shared unit
  typedef struct packed {
    logic    div_load;
    logic    mul_load;
    logic    step;
    wrv_op_e op;
  } wrv_unit_cmd_t;

  // Strobes from the sequencer to the datapath registers
  typedef struct packed {
    logic in_ready;
    logic mean_upd;
    logic acc;
    logic result;
  } wrv_ctrl_t;

endpackage

[src/welford_row_mean_variance.sv]
// Welford row mean and population variance, Q8.8 samples in, Q8.8 mean and
// Q16.16 variance out. Each sample is worked on by a 33-step divide and a 33-step
// multiply on the shared adder, and the next sample is taken only once that work
// is through. The last sample of a row adds a 48-step divide before the result is
// registered.
// Reset clears count, mean and sum, sets the row length to 128, no result held.
module welford_row_mean_variance (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                row_length_we_i,
  input  logic [wrv_pkg::CFG_W-1:0]           row_length_i,
  input  logic                                sample_valid_i,
  output logic                                sample_ready_o,
  input  logic signed [wrv_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                result_valid_o,
  input  logic                                result_ready_i,
  output logic signed [wrv_pkg::SAMPLE_W-1:0] row_mean_o,
  output logic [wrv_pkg::VAR_W-1:0]           row_variance_o
);
  import wrv_pkg::*;

  wrv_unit_cmd_t cmd;
  wrv_ctrl_t     ctrl;

  logic [CFG_W-1:0]    row_length_q;
  logic [CNT_W-1:0]    count_q;
  logic [MEAN_W-1:0]   mean_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                delta_neg_q;
  logic [DELTA_W-1:0]  delta_mag_q;
  logic                prod_neg_q;
  logic                result_valid_q;
  logic [SAMPLE_W-1:0] row_mean_q;
  logic [VAR_W-1:0]    row_variance_q;

  logic [CNT_W-1:0]    n, eff_len;
  logic                row_done, out_free, in_acc;
  logic [DELTA_W-1:0]  x_in, x_held, mean_ext, delta, delta_mag, delta2, delta2_mag;
  logic [QUO_W-1:0]    dividend, quotient;
  logic [MEAN_W-1:0]   quo_mean, mean_new;
  logic [SUM_W-1:0]    product, sum_d;
  logic [MEAN_W-FRAC_SH-1:0] mean_div;
  logic [SAMPLE_W-1:0] mean_sat;
  logic [VAR_W-1:0]    var_sat;

  // Count and row length handling
  assign n = count_q + CNT_W'(1);

  always_comb begin
    priority if (row_length_q == '0) begin
      eff_len = CNT_W'(1);
    end else if (row_length_q > MAX_ROW_LENGTH) begin
      eff_len = MAX_ROW_LENGTH;
    end else begin
      eff_len = row_length_q;
    end
  end

  assign row_done = (n >= eff_len);
  assign out_free = !result_valid_q || result_ready_i;
  assign in_acc   = sample_valid_i && ctrl.in_ready;

  // Sample in Q16.16 and difference against the running mean
  assign x_in = {{(DELTA_W-SAMPLE_W-FRAC_SH){sample_i[SAMPLE_W-1]}}, sample_i,
                 {FRAC_SH{1'b0}}};
  assign x_held = {{(DELTA_W-SAMPLE_W-FRAC_SH){sample_q[SAMPLE_W-1]}}, sample_q,
                   {FRAC_SH{1'b0}}};
  assign mean_ext   = {mean_q[MEAN_W-1], mean_q};
  assign delta      = x_in - mean_ext;
  assign delta_mag  = delta[DELTA_W-1] ? -delta : delta;
  assign delta2     = x_held - mean_ext;
  assign delta2_mag = delta2[DELTA_W-1] ? -delta2 : delta2;

  // Dividend: the row sum in Q32.16 at the end of a row, else the difference
  assign dividend = ctrl.acc ? sum_d[SUM_W-1:SUM_W-QUO_W]
                             : {delta_mag, {(QUO_W-DELTA_W){1'b0}}};

  wrv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_valid_i),
    .row_done_i (row_done),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .ctrl_o     (ctrl)
  );

  wrv_unit u_unit (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .dividend_i (dividend),
    .divisor_i  (n),
    .mcand_i    (delta_mag_q),
    .mplier_i   (delta2_mag),
    .quotient_o (quotient),
    .product_o  (product)
  );

  // Mean update: signed quotient, truncated toward zero, wraps at 32 bits
  assign quo_mean = delta_neg_q ? -quotient[MEAN_W-1:0] : quotient[MEAN_W-1:0];
  assign mean_new = mean_q + quo_mean;

  // Accumulate the signed product into the deviation sum
  assign sum_d = sum_q + (prod_neg_q ? -product : product);

  // Mean to Q8.8, truncated toward zero and saturated
  always_comb begin
    mean_div = mean_q[MEAN_W-1:FRAC_SH] +
               (MEAN_W-FRAC_SH)'(mean_q[MEAN_W-1] && (|mean_q[FRAC_SH-1:0]));
    priority if (!mean_div[MEAN_W-FRAC_SH-1] &&
                 (|mean_div[MEAN_W-FRAC_SH-2:SAMPLE_W-1])) begin
      mean_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (mean_div[MEAN_W-FRAC_SH-1] &&
                 !(&mean_div[MEAN_W-FRAC_SH-2:SAMPLE_W-1])) begin
      mean_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      mean_sat = mean_div[SAMPLE_W-1:0];
    end
  end

  // Variance saturated to 32 bits
  assign var_sat = (|quotient[QUO_W-1:VAR_W]) ? '1 : quotient[VAR_W-1:0];

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= ROW_LEN_RESET;
    end else if (row_length_we_i) begin
      row_length_q <= row_length_i;
    end
  end

  // Running state: advance on each item, clear when a row is given out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mean_q  <= '0;
      sum_q   <= '0;
    end else if (ctrl.result) begin
      count_q <= '0;
      mean_q  <= '0;
      sum_q   <= '0;
    end else begin
      if (ctrl.mean_upd) mean_q <= mean_new;
      if (ctrl.acc) begin
        sum_q <= sum_d;
        if (!row_done) count_q <= n;
      end
    end
  end

  // Hold the accepted item and the signs for the current update
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q    <= sample_i;
      delta_neg_q <= delta[DELTA_W-1];
      delta_mag_q <= delta_mag;
    end
    if (cmd.mul_load) begin
      prod_neg_q <= delta_neg_q ^ delta2[DELTA_W-1];
    end
  end

  // Output register: hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else if (ctrl.result) begin
      result_valid_q <= 1'b1;
    end else if (result_ready_i) begin
      result_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.result) begin
      row_mean_q     <= mean_sat;
      row_variance_q <= var_sat;
    end
  end

  assign sample_ready_o = ctrl.in_ready;
  assign result_valid_o = result_valid_q;
  assign row_mean_o     = row_mean_q;
  assign row_variance_o = row_variance_q;

endmodule

[src/wrv_unit.sv]
// Shared arithmetic unit: one 64-bit adder used for restoring division
// (one quotient bit a cycle) and for shift-add multiplication (one bit a cycle).
// Depends on wrv_pkg.
module wrv_unit (
  input  logic                          clk_i,
  input  wrv_pkg::wrv_unit_cmd_t        cmd_i,
  input  logic [wrv_pkg::QUO_W-1:0]     dividend_i,
  input  logic [wrv_pkg::CNT_W-1:0]     divisor_i,
  input  logic [wrv_pkg::DELTA_W-1:0]   mcand_i,
  input  logic [wrv_pkg::DELTA_W-1:0]   mplier_i,
  output logic [wrv_pkg::QUO_W-1:0]     quotient_o,
  output logic [wrv_pkg::SUM_W-1:0]     product_o
);
  import wrv_pkg::*;

  logic [QUO_W-1:0]   shreg_q;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [CNT_W-1:0]   divisor_q;
  logic [SUM_W-1:0]   acc_q;
  logic [DELTA_W-1:0] mcand_q, mplier_q;

  logic [CNT_W:0]     rem_sh;
  logic [SUM_W-1:0]   add_a, add_b;
  logic               add_cin;
  logic [SUM_W:0]     sum;
  logic               carry;

  assign rem_sh = {rem_q, shreg_q[QUO_W-1]};

  // Select adder operands for the current operation
  always_comb begin
    unique case (cmd_i.op)
      OP_DIV: begin
        add_a   = SUM_W'(rem_sh);
        add_b   = ~SUM_W'(divisor_q);
        add_cin = 1'b1;
      end
      OP_MUL: begin
        add_a   = {acc_q[SUM_W-2:0], 1'b0};
        add_b   = mplier_q[DELTA_W-1] ? SUM_W'(mcand_q) : '0;
        add_cin = 1'b0;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
      end
    endcase
  end

  // The one shared adder
  assign sum   = {1'b0, add_a} + {1'b0, add_b} + (SUM_W + 1)'(add_cin);
  assign carry = sum[SUM_W];

  // Keep the difference when the shifted remainder reaches the divisor
  assign rem_d = carry ? sum[CNT_W-1:0] : rem_sh[CNT_W-1:0];

  // Divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      shreg_q   <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (cmd_i.step && cmd_i.op == OP_DIV) begin
      shreg_q <= {shreg_q[QUO_W-2:0], carry};
      rem_q   <= rem_d;
    end
  end

  // Multiplier registers, most significant multiplier bit first
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      acc_q    <= '0;
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
    end else if (cmd_i.step && cmd_i.op == OP_MUL) begin
      acc_q    <= sum[SUM_W-1:0];
      mplier_q <= {mplier_q[DELTA_W-2:0], 1'b0};
    end
  end

  assign quotient_o = shreg_q;
  assign product_o  = acc_q;

endmodule

[src/wrv_ctrl.sv]
// Sequencer for the Welford update: divide, update mean, multiply,
// accumulate and, at the end of a row, divide the sum for the variance.
// Depends on wrv_pkg.
module wrv_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    row_done_i,
  input  logic                    out_free_i,
  output wrv_pkg::wrv_unit_cmd_t  cmd_o,
  output wrv_pkg::wrv_ctrl_t      ctrl_o
);
  import wrv_pkg::*;

  wrv_state_e        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              last_step;

  assign last_step = (cnt_q == STEP_W'(1));

  // State and step counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_DIV_MEAN;
      ST_DIV_MEAN: if (last_step) state_d = ST_MEAN_UPD;
      ST_MEAN_UPD: state_d = ST_MUL_LOAD;
      ST_MUL_LOAD: state_d = ST_MUL;
      ST_MUL:      if (last_step) state_d = ST_ACC;
      ST_ACC:      state_d = row_done_i ? ST_DIV_VAR : ST_IDLE;
      ST_DIV_VAR:  if (last_step) state_d = ST_RESULT;
      ST_RESULT:   if (out_free_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Step counter: load at the start of each iteration, count down during it
  always_comb begin
    cnt_d = cnt_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) cnt_d = MEAN_STEPS;
      ST_MUL_LOAD: cnt_d = MUL_STEPS;
      ST_ACC:      if (row_done_i) cnt_d = VAR_STEPS;
      ST_DIV_MEAN,
      ST_MUL,
      ST_DIV_VAR:  cnt_d = cnt_q - STEP_W'(1);
      default:     cnt_d = cnt_q;
    endcase
  end

  // Outputs per state
  always_comb begin
    cmd_o  = '{div_load: 1'b0, mul_load: 1'b0, step: 1'b0, op: OP_DIV};
    ctrl_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        cmd_o.div_load  = in_valid_i;
      end
      ST_DIV_MEAN: cmd_o.step = 1'b1;
      ST_MEAN_UPD: ctrl_o.mean_upd = 1'b1;
      ST_MUL_LOAD: begin
        cmd_o.mul_load = 1'b1;
        cmd_o.op       = OP_MUL;
      end
      ST_MUL: begin
        cmd_o.step = 1'b1;
        cmd_o.op   = OP_MUL;
      end
      ST_ACC: begin
        ctrl_o.acc     = 1'b1;
        cmd_o.div_load = row_done_i;
      end
      ST_DIV_VAR: cmd_o.step = 1'b1;
      ST_RESULT:  ctrl_o.result = out_free_i;
      default: begin
        cmd_o  = '{div_load: 1'b0, mul_load: 1'b0, step: 1'b0, op: OP_DIV};
        ctrl_o = '0;
      end
    endcase
  end

endmodule

[src/wrv_checker.sv]
// Port-level checks for welford_row_mean_variance, attached by bind.
// Depends on wrv_pkg and the top level's ports.
module wrv_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                sample_valid_i,
  input logic                                sample_ready_o,
  input logic                                result_valid_o,
  input logic                                result_ready_i,
  input logic signed [wrv_pkg::SAMPLE_W-1:0] row_mean_o,
  input logic [wrv_pkg::VAR_W-1:0]           row_variance_o
);
  import wrv_pkg::*;

  // Hold a stalled result unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=>
      result_valid_o && $stable(row_mean_o) && $stable(row_variance_o))
    else $error("stalled result changed or dropped");

  // Drop ready once an item is accepted; only the start of its work is checked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && sample_ready_o |=> !sample_ready_o ##1 !sample_ready_o)
    else $error("new item taken while the previous one is still in work");

  // No result can be raised in the first cycles after an item is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && sample_ready_o |=>
      !$rose(result_valid_o) ##1 !$rose(result_valid_o))
    else $error("result raised too soon after an accepted item");

endmodule

bind welford_row_mean_variance wrv_checker u_wrv_checker (.*);
